// File: src/bmpgd_pkg.sv
// ----------------------------------------------------------------------------
// BMP gray decoder package
// Shared types and constants for the BMP gray stream decoder.
// ----------------------------------------------------------------------------
package bmpgd_pkg;

   localparam int unsigned MaxWidth  = 4096;
   localparam int unsigned MaxHeight = 4096;
   localparam int unsigned PalDepth  = 256;
   localparam int unsigned PalAw     = $clog2(PalDepth);

   typedef enum logic [3:0] {
      PH_SIG   = 4'd0,
      PH_FHDR  = 4'd1,
      PH_INFO  = 4'd2,
      PH_XINFO = 4'd3,
      PH_PAL   = 4'd4,
      PH_GAP   = 4'd5,
      PH_PIX   = 4'd6,
      PH_WAIT  = 4'd7
   } phase_type;

   typedef enum logic [3:0] {
      ST_OK        = 4'd0,
      ST_SIG       = 4'd1,
      ST_SHORT_FH  = 4'd2,
      ST_SHORT_IH  = 4'd3,
      ST_UNSUP     = 4'd4,
      ST_DEPTH     = 4'd5,
      ST_DIMS      = 4'd6,
      ST_SHORT_PAL = 4'd7,
      ST_OFFSET    = 4'd8,
      ST_SHORT_PIX = 4'd9
   } status_type;

   // palette write and read request from the parser
   typedef struct packed {
      logic              wr_en;
      logic [PalAw-1:0]  wr_addr;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [PalAw-1:0]  rd_addr;
   } pal_req_type;

   // pixel-stage result carried into the lookup stage
   typedef struct packed {
      logic        valid;
      logic        pix;
      logic        use_pal;
      logic [11:0] col;
      logic [11:0] row;
      logic [7:0]  gray;
      logic [3:0]  status;
      logic        done;
   } stage_type;

   // short-data status of a phase when the file ends early
   function automatic status_type short_code(input phase_type ph);
      status_type s;
      unique case (ph)
         PH_SIG:            s = ST_SIG;
         PH_FHDR:           s = ST_SHORT_FH;
         PH_INFO:           s = ST_SHORT_IH;
         PH_XINFO, PH_PAL:  s = ST_SHORT_PAL;
         PH_GAP, PH_PIX:    s = ST_SHORT_PIX;
         default:           s = ST_OK;
      endcase
      return s;
   endfunction

endpackage

// File: src/bmpgd_palette_ram.sv
// ----------------------------------------------------------------------------
// BMP gray decoder palette RAM
// One write port and one registered read port for the palette blue bytes.
// ----------------------------------------------------------------------------
module bmpgd_palette_ram (
   input  logic                        clock,
   input  bmpgd_pkg::pal_req_type      req,
   output logic [7:0]                  rd_data
);

   logic [7:0] mem [bmpgd_pkg::PalDepth];
   logic [7:0] rd_data_ff;

   // write and read, read data registered
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/bmpgd_parser.sv
// ----------------------------------------------------------------------------
// BMP gray decoder parser
// Header assembly, checks, palette fill, padding skip and pixel counting.
// ----------------------------------------------------------------------------
module bmpgd_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [7:0]                byte_value,
   input  logic                      last_byte,
   output bmpgd_pkg::pal_req_type    pal_req,
   output bmpgd_pkg::stage_type      stage
);

   bmpgd_pkg::phase_type phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] fa_ff, fa_in;
   logic [31:0] poff_ff, poff_in;
   logic [31:0] isize_ff, isize_in;
   logic [31:0] rw_ff, rw_in, rh_ff, rh_in, rc_ff, rc_in;
   logic [15:0] rb_ff, rb_in;
   logic        rcomp_ff, rcomp_in;
   logic [12:0] w_ff, w_in, h_ff, h_in;
   logic        td_ff, td_in, idx_ff, idx_in;
   logic [31:0] psize_ff, psize_in, pcnt_ff, pcnt_in;
   logic [1:0]  eb_ff, eb_in, pb_ff, pb_in;
   logic [11:0] col_ff, col_in, line_ff, line_in;
   logic [13:0] rbc_ff, rbc_in;
   logic [14:0] data_len_ff, data_len_in, row_last_ff, row_last_in;

   logic [31:0] used, hneg, habs;
   logic [32:0] xend;
   logic [3:0]  err;
   logic        pix, done;
   logic [11:0] col_o, row_o;
   logic [14:0] w3;

   always_comb begin
      phase_in = phase_ff; pos_in = pos_ff; poff_in = poff_ff;
      isize_in = isize_ff; rw_in = rw_ff; rh_in = rh_ff; rc_in = rc_ff;
      rb_in = rb_ff; rcomp_in = rcomp_ff; w_in = w_ff; h_in = h_ff;
      td_in = td_ff; idx_in = idx_ff; psize_in = psize_ff; pcnt_in = pcnt_ff;
      eb_in = eb_ff; pb_in = pb_ff; col_in = col_ff; line_in = line_ff;
      rbc_in = rbc_ff; data_len_in = data_len_ff; row_last_in = row_last_ff;
      err = bmpgd_pkg::ST_OK; pix = 1'b0; done = 1'b0;
      col_o = '0; row_o = '0;
      pal_req = '0;
      hneg = 32'd0 - rh_ff;
      habs = rh_ff[31] ? hneg : rh_ff;
      w3 = {2'b00, rw_ff[12:0]} + {1'b0, rw_ff[12:0], 1'b0};
      xend = 33'd14 + {1'b0, isize_ff};

      if (pos_ff != 32'hFFFF_FFFF) pos_in = pos_ff + 32'd1;
      used = pos_in;
      fa_in = {byte_value, fa_ff[31:8]};

      unique case (phase_ff)
         bmpgd_pkg::PH_SIG: begin
            if (byte_value != ((pos_ff == 32'd0) ? 8'h42 : 8'h4D)) err = bmpgd_pkg::ST_SIG;
            else if (pos_ff != 32'd0) phase_in = bmpgd_pkg::PH_FHDR;
         end
         bmpgd_pkg::PH_FHDR: begin
            if (pos_ff == 32'd13) begin
               poff_in = fa_in; phase_in = bmpgd_pkg::PH_INFO;
            end
         end
         bmpgd_pkg::PH_INFO: begin
            priority if (pos_ff == 32'd17) isize_in = fa_in;
            else if (pos_ff == 32'd21) rw_in = fa_in;
            else if (pos_ff == 32'd25) rh_in = fa_in;
            else if (pos_ff == 32'd29) rb_in = fa_in[31:16];
            else if (pos_ff == 32'd33) rcomp_in = (fa_in != 32'd0);
            else if (pos_ff == 32'd49) rc_in = fa_in;
            else if (pos_ff == 32'd53) begin
               // header checks in fixed order
               priority if (isize_ff < 32'd40 || rcomp_ff) err = bmpgd_pkg::ST_UNSUP;
               else if (rb_ff != 16'd24 && rb_ff != 16'd8) err = bmpgd_pkg::ST_DEPTH;
               else if (rw_ff == 32'd0 || rw_ff[31] || rh_ff == 32'd0 ||
                        rw_ff > 32'(bmpgd_pkg::MaxWidth) ||
                        habs > 32'(bmpgd_pkg::MaxHeight)) begin
                  err = bmpgd_pkg::ST_DIMS;
                  td_in = rh_ff[31];
               end else begin
                  td_in = rh_ff[31];
                  w_in = rw_ff[12:0]; h_in = habs[12:0];
                  idx_in = (rb_ff == 16'd8);
                  // data bytes per row and last byte index of padded row
                  data_len_in = (rb_ff == 16'd8) ? {2'b00, rw_ff[12:0]} : w3;
                  row_last_in = ((((rb_ff == 16'd8) ? {2'b00, rw_ff[12:0]} : w3)
                                 + 15'd3) | 15'd3) - 15'd4;
                  if (rb_ff != 16'd8) begin
                     if (poff_ff < used) err = bmpgd_pkg::ST_OFFSET;
                     else phase_in = (poff_ff == used) ? bmpgd_pkg::PH_PIX
                                                      : bmpgd_pkg::PH_GAP;
                  end else begin
                     psize_in = (rc_ff != 32'd0) ? rc_ff : 32'd256;
                     pcnt_in = '0; eb_in = '0;
                     phase_in = (isize_ff == 32'd40) ? bmpgd_pkg::PH_PAL
                                                     : bmpgd_pkg::PH_XINFO;
                  end
               end
            end
         end
         bmpgd_pkg::PH_XINFO: begin
            if ({1'b0, used} == xend) phase_in = bmpgd_pkg::PH_PAL;
         end
         bmpgd_pkg::PH_PAL: begin
            if (eb_ff == 2'd0 && pcnt_ff < 32'(bmpgd_pkg::PalDepth)) begin
               pal_req.wr_en = 1'b1;
               pal_req.wr_addr = pcnt_ff[bmpgd_pkg::PalAw-1:0];
               pal_req.wr_data = byte_value;
            end
            if (eb_ff == 2'd3) begin
               eb_in = '0;
               pcnt_in = pcnt_ff + 32'd1;
               if (pcnt_in == psize_ff) begin
                  if (poff_ff < used) err = bmpgd_pkg::ST_OFFSET;
                  else phase_in = (poff_ff == used) ? bmpgd_pkg::PH_PIX
                                                   : bmpgd_pkg::PH_GAP;
               end
            end else begin
               eb_in = eb_ff + 2'd1;
            end
         end
         bmpgd_pkg::PH_GAP: begin
            if (used == poff_ff) phase_in = bmpgd_pkg::PH_PIX;
         end
         bmpgd_pkg::PH_PIX: begin
            if ({1'b0, rbc_ff} < data_len_ff) begin
               if (idx_ff) pix = 1'b1;
               else if (pb_ff == 2'd2) begin
                  pix = 1'b1; pb_in = '0;
               end else pb_in = pb_ff + 2'd1;
               if (pix) begin
                  col_o = col_ff;
                  row_o = td_ff ? line_ff : (h_ff[11:0] - 12'd1 - line_ff);
                  done = ({1'b0, line_ff} == h_ff - 13'd1) &&
                         ({1'b0, col_ff} == w_ff - 13'd1);
                  col_in = col_ff + 12'd1;
                  if (done) phase_in = bmpgd_pkg::PH_WAIT;
               end
            end
            rbc_in = rbc_ff + 14'd1;
            if ({1'b0, rbc_ff} >= row_last_ff) begin
               rbc_in = '0; col_in = '0; pb_in = '0; line_in = line_ff + 12'd1;
            end
         end
         default: ;
      endcase

      if (err == bmpgd_pkg::ST_OK && last_byte && phase_in != bmpgd_pkg::PH_WAIT) begin
         err = bmpgd_pkg::short_code(phase_in);
         pix = 1'b0;
      end
      if (err != bmpgd_pkg::ST_OK) phase_in = bmpgd_pkg::PH_WAIT;

      // palette lookup for indexed pixels
      pal_req.rd_en = pix && idx_ff;
      pal_req.rd_addr = byte_value;

      stage.valid   = step && (pix || err != bmpgd_pkg::ST_OK);
      stage.pix     = pix;
      stage.use_pal = idx_ff && ({24'd0, byte_value} < psize_ff);
      stage.col     = pix ? col_o : 12'd0;
      stage.row     = pix ? row_o : 12'd0;
      stage.gray    = pix ? (idx_ff ? byte_value : fa_in[15:8]) : 8'd0;
      stage.status  = err;
      stage.done    = (err != bmpgd_pkg::ST_OK) || done;
      if (!step) begin
         pal_req.wr_en = 1'b0;
         pal_req.rd_en = 1'b0;
      end
   end

   // parser state, cleared at reset and at the end of each file
   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         phase_ff <= bmpgd_pkg::PH_SIG; pos_ff <= '0; fa_ff <= '0; poff_ff <= '0;
         isize_ff <= '0; rw_ff <= '0; rh_ff <= '0; rc_ff <= '0; rb_ff <= '0;
         rcomp_ff <= 1'b0; w_ff <= '0; h_ff <= '0; td_ff <= 1'b0; idx_ff <= 1'b0;
         psize_ff <= '0; pcnt_ff <= '0; eb_ff <= '0; pb_ff <= '0; col_ff <= '0;
         line_ff <= '0; rbc_ff <= '0; data_len_ff <= '0; row_last_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in; pos_ff <= pos_in; fa_ff <= fa_in; poff_ff <= poff_in;
         isize_ff <= isize_in; rw_ff <= rw_in; rh_ff <= rh_in; rc_ff <= rc_in;
         rb_ff <= rb_in; rcomp_ff <= rcomp_in; w_ff <= w_in; h_ff <= h_in;
         td_ff <= td_in; idx_ff <= idx_in; psize_ff <= psize_in; pcnt_ff <= pcnt_in;
         eb_ff <= eb_in; pb_ff <= pb_in; col_ff <= col_in; line_ff <= line_in;
         rbc_ff <= rbc_in; data_len_ff <= data_len_in; row_last_ff <= row_last_in;
      end
   end

endmodule

// File: src/bmp_gray_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// BMP gray stream decoder core
// Decodes 24-bit and 8-bit palette BMP files, one byte per word, to gray.
// ----------------------------------------------------------------------------
// Takes one file byte per cycle and gives at most one result word per byte,
// passing through the lookup stage register, which lines up with the registered
// palette RAM read, and then the output queue. A two-entry output queue lets the
// input keep flowing while a result waits; req_tready drops only when that queue
// could overflow, with a word leaving in the same cycle counted as room, so bytes
// stream back to back as long as the result side keeps up. The palette RAM holds
// no reset value; it is filled from each 8-bit file.
module bmp_gray_stream_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [0] pixel_valid, [12:1] pixel_column,
                                    // [24:13] pixel_row, [32:25] gray_level,
                                    // [36:33] status, [37] image_done
);

   logic                   step;
   bmpgd_pkg::pal_req_type pal_req;
   bmpgd_pkg::stage_type   stage, st_ff;
   logic [7:0]             pal_data;
   logic [37:0]            word;
   logic [37:0]            q_ff [2];
   logic [1:0]             cnt_ff, cnt_in;
   logic                   rd_ff, wr_ff;
   logic                   push, pop;

   // accept unless queue plus stage could overflow, a popped word frees a slot
   assign req_tready = ({1'b0, cnt_ff} + {2'b00, st_ff.valid}) <= ({2'b00, pop} + 3'd1);
   assign step = req_tvalid && req_tready;

   bmpgd_parser u_parser (
      .clock(clock), .reset(reset), .step(step), .byte_value(req_tdata),
      .last_byte(req_tlast), .pal_req(pal_req), .stage(stage)
   );

   bmpgd_palette_ram u_ram (.clock(clock), .req(pal_req), .rd_data(pal_data));

   // lookup stage
   always_ff @(posedge clock) begin
      if (reset) st_ff.valid <= 1'b0;
      else st_ff.valid <= stage.valid;
      st_ff.pix <= stage.pix; st_ff.use_pal <= stage.use_pal;
      st_ff.col <= stage.col; st_ff.row <= stage.row; st_ff.gray <= stage.gray;
      st_ff.status <= stage.status; st_ff.done <= stage.done;
   end

   assign word = {st_ff.done, st_ff.status,
                  (st_ff.pix && st_ff.use_pal) ? pal_data : st_ff.gray,
                  st_ff.row, st_ff.col, st_ff.pix};

   // output queue
   assign push = st_ff.valid;
   assign pop  = rsp_tvalid && rsp_tready;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; rd_ff <= 1'b0; wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (pop) rd_ff <= ~rd_ff;
         if (push) wr_ff <= ~wr_ff;
      end
      if (push) q_ff[wr_ff] <= word;
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {2'b00, q_ff[rd_ff]};

   // queue never exceeds two words
   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("output queue overflow");
   // a full queue with nothing leaving stalls the input
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !pop) |-> !req_tready)
      else $error("input accepted with full queue");
   // an accepted byte reaches the lookup stage only if it was accepted
   assert property (@(posedge clock) disable iff (reset)
      st_ff.valid |-> $past(step))
      else $error("result without accepted byte");

endmodule
